// ===== hw/rtl/dwvd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwvd_pkg
// Shared codes and controller/datapath interface types for the deque block.
// ----------------------------------------------------------------------------
package dwvd_pkg;

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DELETE     = 3'd4;
    localparam logic [2:0] OP_READ_FIRST = 3'd5;
    localparam logic [2:0] OP_READ_LAST  = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // most elements one read gives out
    localparam int unsigned READ_LIMIT = 64;

    typedef struct packed {
        logic       take;        // latch accepted item
        logic       commit;      // apply push / pop / clear
        logic       del_start;
        logic       del_step;
        logic       del_finish;
        logic       rd_start;
        logic       rd_issue;    // read entry RAM at current read position
        logic       rd_emit;     // load read element into output register
        logic       emit;        // load status-only result
        logic [1:0] emit_st;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       rd_zero;     // read count clamps to zero
        logic       rd_last;     // current element is the final one
        logic       del_done;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/dwvd_ram.sv =====
// ----------------------------------------------------------------------------
// dwvd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dwvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwvd_ctrl
// Sequencer: takes one item at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module dwvd_ctrl
    import dwvd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_EMIT     = 3'd2;
    localparam logic [2:0] S_DEL      = 3'd3;
    localparam logic [2:0] S_RD_ADDR  = 3'd4;
    localparam logic [2:0] S_RD_DATA  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_emit_st, n_emit_st;

    always_comb begin
        n_state   = r_state;
        n_emit_st = r_emit_st;
        o_cmd     = '0;
        o_cmd.emit_st = r_emit_st;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state   = S_EMIT;
                n_emit_st = ST_OK;
                case (i_stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (i_stat.full) begin
                            n_emit_st = ST_FULL;
                        end else begin
                            o_cmd.commit = 1'b1;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (i_stat.empty) begin
                            n_emit_st = ST_EMPTY;
                        end else begin
                            o_cmd.commit = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.empty) begin
                            n_emit_st = ST_EMPTY;
                        end else begin
                            o_cmd.del_start = 1'b1;
                            n_state         = S_DEL;
                        end
                    end
                    OP_READ_FIRST, OP_READ_LAST: begin
                        if (i_stat.empty) begin
                            n_emit_st = ST_EMPTY;
                        end else if (!i_stat.rd_zero) begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_RD_ADDR;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.commit = 1'b1;
                    end
                    default: begin
                        o_cmd.commit = 1'b0;
                    end
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_stat.del_done) begin
                    o_cmd.del_finish = 1'b1;
                    n_emit_st        = ST_OK;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.del_step = 1'b1;
                end
            end
            S_RD_ADDR: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = i_stat.rd_last ? S_IDLE : S_RD_ADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_emit_st <= ST_OK;
        end else begin
            r_state   <= n_state;
            r_emit_st <= n_emit_st;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/dwvd_dp.sv =====
// ----------------------------------------------------------------------------
// dwvd_dp
// Datapath: ring pointers, entry RAM, delete compaction walk, read walk and
// the output register.
// ----------------------------------------------------------------------------
module dwvd_dp
    import dwvd_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_element,
    output logic               o_has_element,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(CAPACITY)) begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]    r_op;
    logic [31:0]   r_val;
    logic [AW-1:0] r_front;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n, r_start, r_i;
    logic [CW-1:0] r_r, r_w;
    logic          r_pend;
    logic          r_out_valid;
    logic [31:0]   r_elem;
    logic          r_has;
    logic [1:0]    r_st;
    logic          r_last;

    logic          out_free;
    logic [CW-1:0] n_rd;
    logic [AW-1:0] front_dec;
    logic          del_rd;
    logic          del_wr;
    logic          is_push;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    // clamp read count: negative -> 0, then to contents, then to READ_LIMIT
    always_comb begin
        if (r_val[31]) begin
            n_rd = '0;
        end else if (r_val > 32'(r_count)) begin
            n_rd = r_count;
        end else begin
            n_rd = r_val[CW-1:0];
        end
        if (32'(n_rd) > READ_LIMIT) begin
            n_rd = CW'(READ_LIMIT);
        end
    end

    assign out_free  = !r_out_valid || !i_stall;
    assign front_dec = (r_front == '0) ? AW'(CAPACITY - 1) : r_front - 1'b1;
    assign is_push   = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK);
    assign del_rd    = i_cmd.del_step && (r_r < r_count);
    assign del_wr    = i_cmd.del_step && r_pend && (mem_rdata != r_val);

    always_comb begin
        mem_re    = i_cmd.rd_issue || del_rd;
        mem_raddr = i_cmd.rd_issue ? ring(r_front, r_start + r_i) : ring(r_front, r_r);
        mem_we    = 1'b0;
        mem_waddr = ring(r_front, r_w);
        mem_wdata = mem_rdata;
        if (i_cmd.commit && is_push) begin
            mem_we    = 1'b1;
            mem_wdata = r_val;
            mem_waddr = (r_op == OP_PUSH_FRONT) ? front_dec : ring(r_front, r_count);
        end else if (del_wr) begin
            mem_we = 1'b1;
        end
    end

    dwvd_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // item latch and walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_operation;
            r_val <= i_value;
        end
        if (i_cmd.rd_start) begin
            r_n     <= n_rd;
            r_start <= (r_op == OP_READ_FIRST) ? '0 : r_count - n_rd;
            r_i     <= '0;
        end else if (i_cmd.rd_emit) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.del_start) begin
            r_r <= '0;
            r_w <= '0;
        end else begin
            if (del_rd) begin
                r_r <= r_r + 1'b1;
            end
            if (del_wr) begin
                r_w <= r_w + 1'b1;
            end
        end
    end

    // ring pointers and delete pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= del_rd;
            if (i_cmd.commit) begin
                case (r_op)
                    OP_PUSH_FRONT: begin
                        r_front <= front_dec;
                        r_count <= r_count + 1'b1;
                    end
                    OP_PUSH_BACK: begin
                        r_count <= r_count + 1'b1;
                    end
                    OP_POP_FRONT: begin
                        r_front <= ring(r_front, CW'(1));
                        r_count <= r_count - 1'b1;
                    end
                    OP_POP_BACK: begin
                        r_count <= r_count - 1'b1;
                    end
                    default: begin
                        r_front <= '0;
                        r_count <= '0;
                    end
                endcase
            end else if (i_cmd.del_finish) begin
                r_count <= r_w;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.rd_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_emit) begin
            r_elem <= mem_rdata;
            r_has  <= 1'b1;
            r_st   <= ST_OK;
            r_last <= o_stat.rd_last;
        end else if (i_cmd.emit) begin
            r_elem <= '0;
            r_has  <= 1'b0;
            r_st   <= i_cmd.emit_st;
            r_last <= 1'b1;
        end
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CW'(CAPACITY));
        o_stat.rd_zero  = (n_rd == '0);
        o_stat.rd_last  = ((CW+1)'(r_i) + 1'b1 == (CW+1)'(r_n));
        o_stat.del_done = !(r_r < r_count) && !r_pend;
        o_stat.out_free = out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_element     = r_elem;
    assign o_has_element = r_has;
    assign o_status      = r_st;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/deque_with_value_delete_top.sv =====
// ----------------------------------------------------------------------------
// deque_with_value_delete_top
// Bounded double-ended queue of signed 32-bit words with delete-by-value.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+------------------------------------------
//  input    | i_valid | o_stall | i_operation, i_value
//  result   | o_valid | i_stall | o_element, o_has_element, o_status, o_last
//
//  One item at a time. Push, pop, clear and empty/full cases: dispatch,
//  then result. Delete: one entry a cycle through the single read port of
//  the entry RAM. Read: per element, a RAM read (S_RD_ADDR), then a load
//  into the output (S_RD_DATA). Reset (synchronous) empties the list; the
//  entry RAM is not cleared. A stalled result holds the next result back;
//  the next item is taken while the last result waits.
// ----------------------------------------------------------------------------
module deque_with_value_delete_top
    import dwvd_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_element,
    output logic               o_has_element,
    output logic [1:0]         o_status,
    output logic               o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dwvd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dwvd_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_element     (o_element),
        .o_has_element (o_has_element),
        .o_status      (o_status),
        .o_last        (o_last)
    );

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.commit, cmd.del_start, cmd.del_step, cmd.del_finish,
                  cmd.rd_start, cmd.rd_issue, cmd.rd_emit, cmd.emit}))
        else $error("more than one datapath command");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.rd_emit) |-> stat.out_free)
        else $error("output register overwritten");

    a_elem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_element) |-> (o_status == ST_OK))
        else $error("element result with error status");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken before first finished");
`endif

endmodule
